### rtl/core/stre_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// stre_pkg
// Shared codes, widths and controller/datapath signal groups for the
// segment tree range engine.
// ============================================================================
package stre_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_ELEMENTS = 1024;
    localparam int DEF_DATA_WIDTH   = 32;

    // Fixed field widths of the channels.
    localparam int OP_W        = 2;
    localparam int IDX_W       = 10;
    localparam int VAL_W       = 32;
    localparam int MODE_W      = 2;
    localparam int CNT_W       = 11;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 11;

    localparam logic [CNT_W-1:0] COUNT_RESET = 11'd1024;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_UPDATE = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    // Aggregate kinds.
    localparam logic [MODE_W-1:0] MODE_SUM = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MAX = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MIN = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_MODE  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COUNT = 1'd1;

    // Progress of a stack frame.
    localparam logic [1:0] STG_FIRST      = 2'd0;
    localparam logic [1:0] STG_LEFT_DONE  = 2'd1;
    localparam logic [1:0] STG_RIGHT_DONE = 2'd2;

    typedef enum logic [1:0] {RD_SELF, RD_LEFT, RD_RIGHT} rd_sel_t;
    typedef enum logic [1:0] {CH_LEFT, CH_RIGHT, CH_POINT} child_t;
    typedef enum logic [1:0] {WR_NONE, WR_LEAF, WR_COVER, WR_REFRESH} wr_t;
    typedef enum logic [1:0] {RET_NONE, RET_NEUTRAL, RET_COVER, RET_COMBINE} ret_t;
    typedef enum logic [1:0] {MUL_NONE, MUL_COVER, MUL_REFRESH} mul_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    latch;
        logic    clr_start;
        logic    clr_step;
        logic    push_root;
        logic    push_child;
        child_t  child;
        logic    save_left;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    cap_a;
        logic    cap_b;
        mul_t    mul;
        wr_t     wr;
        ret_t    ret;
        logic    pop;
        logic    next_point;
        logic    out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic              clr_last;
        logic              load_ok;
        logic              empty;
        logic [OP_W-1:0]   op;
        logic [MODE_W-1:0] kind;
        logic              is_leaf;
        logic              disjoint;
        logic              covered;
        logic [1:0]        stage;
        logic              sp_zero;
        logic              pt_last;
        logic              out_full;
    } status_t;

endpackage

### rtl/core/stre_request_if.sv
`timescale 1ns / 1ps
// ============================================================================
// stre_request_if
// Request channel: one operation word with its range and value.
// ============================================================================
interface stre_request_if;
    logic                                valid;
    logic                                ready;
    logic [stre_pkg::OP_W-1:0]           op;
    logic [stre_pkg::IDX_W-1:0]          range_begin;
    logic [stre_pkg::IDX_W-1:0]          range_end;
    logic signed [stre_pkg::VAL_W-1:0]   value;

    modport source (output valid, op, range_begin, range_end, value, input ready);
    modport sink   (input valid, op, range_begin, range_end, value, output ready);
endinterface

### rtl/core/stre_response_if.sv
`timescale 1ns / 1ps
// ============================================================================
// stre_response_if
// Response channel: one query result word.
// ============================================================================
interface stre_response_if;
    logic                              valid;
    logic                              ready;
    logic signed [stre_pkg::VAL_W-1:0] result;
    logic                              range_empty;

    modport source (output valid, result, range_empty, input ready);
    modport sink   (input valid, result, range_empty, output ready);
endinterface

### rtl/core/stre_cfg_if.sv
`timescale 1ns / 1ps
// ============================================================================
// stre_cfg_if
// Configuration write channel: register index and write data.
// ============================================================================
interface stre_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [stre_pkg::CFG_INDEX_W-1:0]    index;
    logic [stre_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/stre_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// stre_ctrl
// Sequencer that walks the tree recursion through the datapath's frame stack.
// ============================================================================
module stre_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              cfg_we,
    input  stre_pkg::status_t status,
    output stre_pkg::cmd_t    cmd
);

    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_START   = 4'd2;
    localparam logic [3:0] S_ENTER   = 4'd3;
    localparam logic [3:0] S_EVAL    = 4'd4;
    localparam logic [3:0] S_COV_WR  = 4'd5;
    localparam logic [3:0] S_RD_L    = 4'd6;
    localparam logic [3:0] S_RD_R    = 4'd7;
    localparam logic [3:0] S_RD_P    = 4'd8;
    localparam logic [3:0] S_REF_MUL = 4'd9;
    localparam logic [3:0] S_REF_WR  = 4'd10;
    localparam logic [3:0] S_RET     = 4'd11;
    localparam logic [3:0] S_RESUME  = 4'd12;
    localparam logic [3:0] S_DONE    = 4'd13;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       is_ask;
    logic       is_add;
    logic       is_point;

    // Walk style for the word in hand.
    assign is_ask   = (status.op == stre_pkg::OP_QUERY);
    assign is_add   = (status.op == stre_pkg::OP_UPDATE) &&
                      (status.kind == stre_pkg::MODE_SUM);
    assign is_point = !is_ask && !is_add;

    assign in_ready = (state_reg == S_IDLE) && !cfg_we;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.child      = stre_pkg::CH_LEFT;
        cmd.rd_sel     = stre_pkg::RD_SELF;
        cmd.mul        = stre_pkg::MUL_NONE;
        cmd.wr         = stre_pkg::WR_NONE;
        cmd.ret        = stre_pkg::RET_NONE;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                priority if (status.op == stre_pkg::OP_LOAD)
                begin
                    cmd.push_root = status.load_ok;
                    state_next    = status.load_ok ? S_ENTER : S_IDLE;
                end
                else if (status.op == stre_pkg::OP_UPDATE)
                begin
                    cmd.push_root = !status.empty;
                    state_next    = status.empty ? S_IDLE : S_ENTER;
                end
                else if (status.op == stre_pkg::OP_QUERY)
                begin
                    if (status.empty)
                    begin
                        cmd.ret    = stre_pkg::RET_NEUTRAL;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.push_root = 1'b1;
                        state_next    = S_ENTER;
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_ENTER:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = stre_pkg::RD_SELF;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                priority if (is_point)
                begin
                    if (status.is_leaf)
                    begin
                        cmd.wr     = stre_pkg::WR_LEAF;
                        state_next = S_RET;
                    end
                    else
                    begin
                        cmd.push_child = 1'b1;
                        cmd.child      = stre_pkg::CH_POINT;
                        state_next     = S_ENTER;
                    end
                end
                else if (status.disjoint)
                begin
                    cmd.ret    = is_ask ? stre_pkg::RET_NEUTRAL : stre_pkg::RET_NONE;
                    state_next = S_RET;
                end
                else if (status.covered)
                begin
                    cmd.mul    = stre_pkg::MUL_COVER;
                    state_next = S_COV_WR;
                end
                else
                begin
                    cmd.push_child = 1'b1;
                    cmd.child      = stre_pkg::CH_LEFT;
                    state_next     = S_ENTER;
                end
            end
            S_COV_WR:
            begin
                if (is_ask)
                begin
                    cmd.ret = stre_pkg::RET_COVER;
                end
                else
                begin
                    cmd.wr = stre_pkg::WR_COVER;
                end
                state_next = S_RET;
            end
            S_RD_L:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = stre_pkg::RD_LEFT;
                state_next = S_RD_R;
            end
            S_RD_R:
            begin
                cmd.cap_a  = 1'b1;
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = stre_pkg::RD_RIGHT;
                state_next = S_RD_P;
            end
            S_RD_P:
            begin
                cmd.cap_b  = 1'b1;
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = stre_pkg::RD_SELF;
                state_next = S_REF_MUL;
            end
            S_REF_MUL:
            begin
                cmd.mul    = stre_pkg::MUL_REFRESH;
                state_next = S_REF_WR;
            end
            S_REF_WR:
            begin
                cmd.wr     = stre_pkg::WR_REFRESH;
                state_next = S_RET;
            end
            S_RET:
            begin
                if (status.sp_zero)
                begin
                    priority if (is_ask)
                    begin
                        state_next = S_DONE;
                    end
                    else if ((status.op == stre_pkg::OP_UPDATE) && is_point &&
                             !status.pt_last)
                    begin
                        cmd.next_point = 1'b1;
                        cmd.push_root  = 1'b1;
                        state_next     = S_ENTER;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.pop    = 1'b1;
                    state_next = S_RESUME;
                end
            end
            S_RESUME:
            begin
                priority if (is_point)
                begin
                    state_next = S_RD_L;
                end
                else if (status.stage == stre_pkg::STG_LEFT_DONE)
                begin
                    cmd.save_left  = is_ask;
                    cmd.push_child = 1'b1;
                    cmd.child      = stre_pkg::CH_RIGHT;
                    state_next     = S_ENTER;
                end
                else if (is_ask)
                begin
                    cmd.ret    = stre_pkg::RET_COMBINE;
                    state_next = S_RET;
                end
                else
                begin
                    state_next = S_RD_L;
                end
            end
            S_DONE:
            begin
                if (!status.out_full)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase

        // A register write restarts the clearing pass from any state.
        if (cfg_we)
        begin
            cmd.clr_start = 1'b1;
            cmd.clr_step  = 1'b0;
            state_next    = S_CLEAR;
        end
    end

endmodule

### rtl/core/stre_datapath.sv
`timescale 1ns / 1ps
// ============================================================================
// stre_datapath
// Node memory, frame stack, multiply and combine logic, configuration and
// the response register.
// ============================================================================
module stre_datapath #(
    parameter int MAX_ELEMENTS = stre_pkg::DEF_MAX_ELEMENTS,
    parameter int DATA_WIDTH   = stre_pkg::DEF_DATA_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  stre_pkg::cmd_t                      cmd,
    output stre_pkg::status_t                   status,
    input  logic                                cfg_we,
    input  logic [stre_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [stre_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [stre_pkg::OP_W-1:0]           req_op,
    input  logic [stre_pkg::IDX_W-1:0]          req_begin,
    input  logic [stre_pkg::IDX_W-1:0]          req_end,
    input  logic signed [stre_pkg::VAL_W-1:0]   req_value,
    input  logic                                rsp_ready,
    output logic                                rsp_valid,
    output logic signed [stre_pkg::VAL_W-1:0]   rsp_result,
    output logic                                rsp_empty
);

    localparam int DW    = DATA_WIDTH;
    localparam int IW    = $clog2(MAX_ELEMENTS);
    localparam int LW    = IW + 1;
    localparam int CW    = (LW > stre_pkg::CNT_W) ? LW : stre_pkg::CNT_W;
    localparam int SLOTS = 4 * MAX_ELEMENTS;
    localparam int NW    = $clog2(SLOTS);
    localparam int SD    = IW + 1;
    localparam int SPW   = $clog2(SD);

    localparam logic [DW-1:0] SIGN_BIT = {1'b1, {(DW - 1){1'b0}}};

    // Configuration registers.
    logic [stre_pkg::MODE_W-1:0] mode_reg;
    logic [stre_pkg::CNT_W-1:0]  count_reg;
    logic [stre_pkg::MODE_W-1:0] kind;

    // Latched word.
    logic [stre_pkg::OP_W-1:0] op_reg;
    logic [IW-1:0]             b_reg;
    logic [IW-1:0]             e_reg;
    logic [IW-1:0]             last_reg;
    logic [IW-1:0]             idx_reg;
    logic [DW-1:0]             v_reg;
    logic                      empty_reg;
    logic                      load_ok_reg;

    // Frame stack.
    logic [NW-1:0]  nd_stk    [SD];
    logic [IW-1:0]  lo_stk    [SD];
    logic [IW-1:0]  hi_stk    [SD];
    logic [1:0]     stg_stk   [SD];
    logic [DW-1:0]  carry_stk [SD];
    logic [DW-1:0]  left_stk  [SD];
    logic [SPW-1:0] sp_reg;
    logic [SPW-1:0] sp_up;

    // Node memory: aggregate in the upper half, pending add in the lower.
    logic [2*DW-1:0] node_mem [SLOTS];
    logic [2*DW-1:0] rdata_reg;
    logic [NW-1:0]   clr_cnt_reg;

    logic [DW-1:0] ret_reg;
    logic [DW-1:0] a_reg;
    logic [DW-1:0] bch_reg;
    logic [DW-1:0] mul_reg;

    logic                        out_valid_reg;
    logic [stre_pkg::VAL_W-1:0]  out_result_reg;
    logic                        out_empty_reg;

    // Intake arithmetic.
    logic [CW-1:0] cnt_w;
    logic [CW-1:0] n_w;
    logic [CW-1:0] last_w;
    logic [CW-1:0] b_w;
    logic [CW-1:0] e_w;
    logic [CW-1:0] ecl_w;

    // Current frame and derived values.
    logic [NW-1:0] nd_c;
    logic [IW-1:0] lo_c;
    logic [IW-1:0] hi_c;
    logic [DW-1:0] carry_c;
    logic [DW-1:0] left_c;
    logic [IW-1:0] mid;
    logic [LW-1:0] len;
    logic [DW-1:0] len_d;
    logic [DW-1:0] agg_r;
    logic [DW-1:0] pend_r;
    logic          go_left;
    logic          go_right;
    logic [NW-1:0] c_nd;
    logic [IW-1:0] c_lo;
    logic [IW-1:0] c_hi;
    logic [DW-1:0] c_carry;
    logic [1:0]    c_stg;
    logic [DW-1:0] mul_op;
    logic [DW-1:0] comb_ab;

    logic            mem_we;
    logic [NW-1:0]   mem_waddr;
    logic [2*DW-1:0] mem_wdata;
    logic [NW-1:0]   mem_raddr;
    logic [DW-1:0]   ret_next;

    function automatic logic [DW-1:0] combine(
        input logic [stre_pkg::MODE_W-1:0] k,
        input logic [DW-1:0]               a,
        input logic [DW-1:0]               b
    );
        logic [DW-1:0] r;
        unique case (k)
            stre_pkg::MODE_MAX: r = ($signed(a) < $signed(b)) ? b : a;
            stre_pkg::MODE_MIN: r = ($signed(b) < $signed(a)) ? b : a;
            default:            r = a + b;
        endcase
        return r;
    endfunction

    function automatic logic [DW-1:0] neutral(input logic [stre_pkg::MODE_W-1:0] k);
        logic [DW-1:0] r;
        unique case (k)
            stre_pkg::MODE_MAX: r = SIGN_BIT;
            stre_pkg::MODE_MIN: r = SIGN_BIT - DW'(1);
            default:            r = '0;
        endcase
        return r;
    endfunction

    // Mode three behaves as sum.
    assign kind = ((mode_reg == stre_pkg::MODE_MAX) || (mode_reg == stre_pkg::MODE_MIN)) ?
                  mode_reg : stre_pkg::MODE_SUM;

    // Element count in use and clipped range end.
    assign cnt_w  = CW'(count_reg);
    assign n_w    = (cnt_w == '0) ? CW'(1) :
                    ((cnt_w > CW'(MAX_ELEMENTS)) ? CW'(MAX_ELEMENTS) : cnt_w);
    assign last_w = n_w - CW'(1);
    assign b_w    = CW'(req_begin);
    assign e_w    = CW'(req_end);
    assign ecl_w  = (e_w > last_w) ? last_w : e_w;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= stre_pkg::MODE_SUM;
            count_reg <= stre_pkg::COUNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                stre_pkg::CFG_MODE:  mode_reg  <= cfg_data[stre_pkg::MODE_W-1:0];
                stre_pkg::CFG_COUNT: count_reg <= cfg_data[stre_pkg::CNT_W-1:0];
                default:             mode_reg  <= mode_reg;
            endcase
        end
    end

    // Word capture and point index.
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg      <= req_op;
            b_reg       <= IW'(req_begin);
            e_reg       <= IW'(ecl_w);
            last_reg    <= IW'(last_w);
            v_reg       <= DW'(req_value);
            empty_reg   <= (b_w > ecl_w);
            load_ok_reg <= (b_w < n_w);
        end
        if (cmd.latch)
        begin
            idx_reg <= IW'(req_begin);
        end
        else if (cmd.next_point)
        begin
            idx_reg <= idx_reg + IW'(1);
        end
    end

    // Current frame.
    assign nd_c    = nd_stk[sp_reg];
    assign lo_c    = lo_stk[sp_reg];
    assign hi_c    = hi_stk[sp_reg];
    assign carry_c = carry_stk[sp_reg];
    assign left_c  = left_stk[sp_reg];
    assign sp_up   = sp_reg + SPW'(1);
    assign mid     = lo_c + ((hi_c - lo_c) >> 1);
    assign len     = LW'(hi_c) - LW'(lo_c) + LW'(1);
    assign len_d   = DW'(len);
    assign agg_r   = rdata_reg[2*DW-1:DW];
    assign pend_r  = rdata_reg[DW-1:0];
    assign go_left = (idx_reg <= mid);

    // Child frame for a push.
    always_comb
    begin
        go_right = (cmd.child == stre_pkg::CH_RIGHT) ||
                   ((cmd.child == stre_pkg::CH_POINT) && !go_left);
        c_nd     = {nd_c[NW-2:0], go_right};
        c_lo     = go_right ? (mid + IW'(1)) : lo_c;
        c_hi     = go_right ? hi_c : mid;
        c_stg    = (cmd.child == stre_pkg::CH_RIGHT) ? stre_pkg::STG_RIGHT_DONE :
                   stre_pkg::STG_LEFT_DONE;
        unique case (cmd.child)
            stre_pkg::CH_LEFT:
                c_carry = (kind == stre_pkg::MODE_SUM) ? (carry_c + pend_r) : '0;
            stre_pkg::CH_RIGHT:
                c_carry = carry_c;
            default:
                c_carry = '0;
        endcase
    end

    // Stack pointer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg <= '0;
        end
        else if (cmd.push_root)
        begin
            sp_reg <= '0;
        end
        else if (cmd.push_child)
        begin
            sp_reg <= sp_up;
        end
        else if (cmd.pop)
        begin
            sp_reg <= sp_reg - SPW'(1);
        end
    end

    // Frame contents.
    always_ff @(posedge clk)
    begin
        if (cmd.push_root)
        begin
            nd_stk[0]    <= NW'(1);
            lo_stk[0]    <= '0;
            hi_stk[0]    <= last_reg;
            stg_stk[0]   <= stre_pkg::STG_FIRST;
            carry_stk[0] <= '0;
        end
        else if (cmd.push_child)
        begin
            stg_stk[sp_reg] <= c_stg;
            if (cmd.child == stre_pkg::CH_LEFT)
            begin
                carry_stk[sp_reg] <= c_carry;
            end
            nd_stk[sp_up]    <= c_nd;
            lo_stk[sp_up]    <= c_lo;
            hi_stk[sp_up]    <= c_hi;
            stg_stk[sp_up]   <= stre_pkg::STG_FIRST;
            carry_stk[sp_up] <= c_carry;
        end
        if (cmd.save_left)
        begin
            left_stk[sp_reg] <= ret_reg;
        end
    end

    // Multiplier by the node span, registered.
    assign mul_op = (cmd.mul == stre_pkg::MUL_COVER) ?
                    ((op_reg == stre_pkg::OP_QUERY) ? carry_c : v_reg) : pend_r;

    always_ff @(posedge clk)
    begin
        if (cmd.mul != stre_pkg::MUL_NONE)
        begin
            mul_reg <= mul_op * len_d;
        end
        if (cmd.cap_a)
        begin
            a_reg <= agg_r;
        end
        if (cmd.cap_b)
        begin
            bch_reg <= agg_r;
        end
    end

    assign comb_ab = combine(kind, a_reg, bch_reg);

    // Memory write selection.
    always_comb
    begin
        mem_we    = cmd.clr_step || (cmd.wr != stre_pkg::WR_NONE);
        mem_waddr = cmd.clr_step ? clr_cnt_reg : nd_c;
        unique case (cmd.wr)
            stre_pkg::WR_LEAF:
                mem_wdata = {v_reg, {DW{1'b0}}};
            stre_pkg::WR_COVER:
                mem_wdata = {agg_r + mul_reg, pend_r + v_reg};
            stre_pkg::WR_REFRESH:
                mem_wdata = {comb_ab + ((kind == stre_pkg::MODE_SUM) ? mul_reg : '0),
                             pend_r};
            default:
                mem_wdata = '0;
        endcase
        unique case (cmd.rd_sel)
            stre_pkg::RD_LEFT:  mem_raddr = {nd_c[NW-2:0], 1'b0};
            stre_pkg::RD_RIGHT: mem_raddr = {nd_c[NW-2:0], 1'b1};
            default:            mem_raddr = nd_c;
        endcase
    end

    // Node memory, one write and one registered read a cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            node_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= node_mem[mem_raddr];
        end
    end

    // Clearing pass counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_start)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_cnt_reg <= clr_cnt_reg + NW'(1);
        end
    end

    // Value handed back up the recursion.
    always_comb
    begin
        unique case (cmd.ret)
            stre_pkg::RET_NEUTRAL:
                ret_next = neutral(kind);
            stre_pkg::RET_COVER:
                ret_next = (kind == stre_pkg::MODE_SUM) ? (agg_r + mul_reg) : agg_r;
            stre_pkg::RET_COMBINE:
                ret_next = combine(kind, left_c, ret_reg);
            default:
                ret_next = ret_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        ret_reg <= ret_next;
        if (cmd.out_load)
        begin
            out_result_reg <= stre_pkg::VAL_W'(ret_reg);
            out_empty_reg  <= empty_reg;
        end
    end

    // Response register: loads while the previous word leaves.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign rsp_valid  = out_valid_reg;
    assign rsp_result = $signed(out_result_reg);
    assign rsp_empty  = out_empty_reg;

    // Status to the controller.
    always_comb
    begin
        status.clr_last = (clr_cnt_reg == NW'(SLOTS - 1));
        status.load_ok  = load_ok_reg;
        status.empty    = empty_reg;
        status.op       = op_reg;
        status.kind     = kind;
        status.is_leaf  = (lo_c == hi_c);
        status.disjoint = (b_reg > hi_c) || (e_reg < lo_c);
        status.covered  = (lo_c >= b_reg) && (hi_c <= e_reg);
        status.stage    = stg_stk[sp_reg];
        status.sp_zero  = (sp_reg == '0);
        status.pt_last  = (idx_reg == e_reg);
        status.out_full = out_valid_reg && !rsp_ready;
    end

endmodule

### rtl/core/segment_tree_range_engine_core.sv
`timescale 1ns / 1ps
// ============================================================================
// segment_tree_range_engine_core
// Segment tree with range add and sum query, or point assign with max/min
// query, over a node memory with one write and one read port.
// ============================================================================
//  Channel   | Direction | Word
//  request   | in        | op, range_begin, range_end, value
//  response  | out       | result, range_empty (queries only)
//  cfg       | in        | index, data (0 mode, 1 element count)
//
// Each tree node visit has a read and a decide step, and a covered node adds a
// write (for a query, a return). Each refresh of a parent runs return, resume,
// three reads, multiply and write, all set by the node memory's one read port.
// A load walks to one leaf and refreshes each parent on the way back; a range
// add or query visits up to four nodes per level; a max/min update repeats a
// point write per element. After reset and after every register write a
// clearing pass over all 4 * MAX_ELEMENTS node slots runs, during which no
// request word is taken. A waiting response word does not block the next request.
module segment_tree_range_engine_core #(
    parameter int MAX_ELEMENTS = stre_pkg::DEF_MAX_ELEMENTS,
    parameter int DATA_WIDTH   = stre_pkg::DEF_DATA_WIDTH
) (
    input  logic            clk,
    input  logic            rst_n,
    stre_request_if.sink    request,
    stre_response_if.source response,
    stre_cfg_if.sink        cfg
);

    stre_pkg::cmd_t    cmd;
    stre_pkg::status_t status;
    logic              cfg_we;

    // Register writes are always taken.
    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid;

    stre_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (request.valid),
        .in_ready (request.ready),
        .cfg_we   (cfg_we),
        .status   (status),
        .cmd      (cmd)
    );

    stre_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .DATA_WIDTH   (DATA_WIDTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg.index),
        .cfg_data   (cfg.data),
        .req_op     (request.op),
        .req_begin  (request.range_begin),
        .req_end    (request.range_end),
        .req_value  (request.value),
        .rsp_ready  (response.ready),
        .rsp_valid  (response.valid),
        .rsp_result (response.result),
        .rsp_empty  (response.range_empty)
    );

    // A register write starts a clearing pass, so no request follows at once.
    a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.valid && cfg.ready |=> !request.ready)
        else $error("request taken right after a register write");

    // One request word at a time.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        request.valid && request.ready |=> !request.ready)
        else $error("second request taken while one is in work");

    // While waiting for work the tree is never written.
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        request.ready |-> (cmd.wr == stre_pkg::WR_NONE) && !cmd.push_child)
        else $error("tree activity while idle");

endmodule
